/* hdl/srib_pkg.sv */
// srib_pkg: shared types and constants for the strided region iov builder
// payload layouts of the stream transactions, item kinds and entry format
// no dependencies
package srib_pkg;

  localparam int unsigned ADDR_W     = 48;
  localparam int unsigned LEN_W      = 40;
  localparam int unsigned KIND_W     = 2;
  localparam int unsigned CAP_W      = 5;
  localparam int unsigned IDX_W      = 4;
  localparam int unsigned ENT_W      = 5;
  localparam int unsigned IN_TDATA_W  = 184;
  localparam int unsigned OUT_TDATA_W = 128;
  localparam int unsigned CFG_DATA_W  = 32;
  localparam int unsigned CFG_ADDR_W  = 3;

  localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_APPEND = 2'd1;
  localparam logic [KIND_W-1:0] KIND_READ   = 2'd2;

  localparam logic REG_CAPACITY = 1'b0;
  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  localparam logic [LEN_W-1:0] LEN_MAX = {LEN_W{1'b1}};

  typedef struct packed {
    logic [ADDR_W-1:0] base;
    logic [LEN_W-1:0]  len;
  } entry_t;

  // last declared field in the lowest bits
  typedef struct packed {
    logic [6:0]        pad;
    logic [IDX_W-1:0]  read_index;
    logic [5:0]        elem_size;
    logic [31:0]       total_blocks;
    logic signed [39:0] stride;
    logic [30:0]       block_len;
    logic [15:0]       region_count;
    logic [ADDR_W-1:0] region_address;
  } in_data_t;

  typedef struct packed {
    logic [1:0]        pad;
    logic [LEN_W-1:0]  entry_len;
    logic [ADDR_W-1:0] entry_base;
    logic [ENT_W-1:0]  entries_used;
    logic              stopped_full;
    logic [31:0]       blocks_done;
  } out_data_t;

endpackage

/* hdl/srib_entry_ram.sv */
// srib_entry_ram: list entry memory, one write port and one registered read port
// depends on srib_pkg for the entry format
module srib_entry_ram
  import srib_pkg::*;
#(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = 4
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  entry_t        wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output entry_t        rdata
);

  entry_t mem [DEPTH];
  entry_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* hdl/strided_region_iov_builder.sv */
// strided_region_iov_builder: top level of the scatter-gather list builder
// depends on srib_pkg and srib_entry_ram
//
// Builds a list of up to MAX_ENTRIES (base, length) entries from strided region
// descriptors and answers one result transaction per input transaction. The list
// lives in a single-port-write entry ram; the last entry is also held in registers
// so that the merge test and the length update of one region complete per cycle.
// An append descriptor walks one region per clock, so it holds the input until
// the walk has ended and the result is registered; clear, read and unused kinds
// go straight from idle to the done state. The result sits in an output register,
// so a stalled result does not keep the block from taking the next input
// transaction. The capacity register lies at byte address 0 of the apb port and
// resets to 16.
module strided_region_iov_builder
  import srib_pkg::*;
#(
  parameter int unsigned MAX_ENTRIES = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // region_address, region_count, block_len, stride, total_blocks, elem_size,
  // read_index
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // kind
  input  logic [KIND_W-1:0]      in_tuser,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // blocks_done, stopped_full, entries_used, entry_base, entry_len
  output logic [OUT_TDATA_W-1:0] out_tdata,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [CFG_ADDR_W-1:0]  paddr,
  input  logic [CFG_DATA_W-1:0]  pwdata,
  output logic [CFG_DATA_W-1:0]  prdata,
  output logic                   pready
);

  localparam int unsigned AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int unsigned CW = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned KW = (CW > CAP_W) ? CW : CAP_W;
  localparam int unsigned XW = (CW > IDX_W) ? CW : IDX_W;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_DONE
  } state_t;

  state_t            state_r;
  logic [CW-1:0]     used_r;
  logic [CAP_W-1:0]  cap_r;
  logic [KIND_W-1:0] kind_r;
  logic [ADDR_W-1:0] addr_r;
  logic [31:0]       left_r;
  logic [31:0]       total_r;
  logic [15:0]       cnt_r;
  logic [30:0]       blk_r;
  logic [39:0]       stride_r;
  logic [5:0]        esize_r;
  logic              stopped_r;
  logic              hit_r;
  logic [ADDR_W-1:0] last_base_r;
  logic [LEN_W-1:0]  last_len_r;
  logic              out_valid_r;
  out_data_t         out_data_r;

  in_data_t          in_d;
  logic              in_acc;
  logic              cfg_wr;
  logic [31:0]       blk_x;
  logic [31:0]       n;
  logic [37:0]       size;
  logic [ADDR_W-1:0] tail_end;
  logic              merge;
  logic [LEN_W:0]    len_sum;
  logic [LEN_W-1:0]  len_merge;
  logic [KW-1:0]     cap_eff;
  logic              full;
  logic [31:0]       left_after;
  logic              last_region;
  logic [ADDR_W-1:0] stride_ext;
  logic [CW-1:0]     used_m1;
  logic [XW-1:0]     idx_x;
  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  entry_t            ram_wdata;
  logic              ram_re;
  entry_t            ram_rdata;
  out_data_t         res;

  assign in_d   = in_data_t'(in_tdata);
  assign in_acc = in_tvalid && in_tready;
  assign cfg_wr = psel && penable && pwrite && pready;

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign pready     = 1'b1;
  assign prdata     = (paddr[2] == REG_CAPACITY) ? {{(CFG_DATA_W-CAP_W){1'b0}}, cap_r}
                                                 : '0;

  // one region of the walk
  assign blk_x      = {1'b0, blk_r};
  assign n          = (left_r > blk_x) ? blk_x : left_r;
  assign size       = {6'b0, n} * {32'b0, esize_r};
  assign tail_end   = last_base_r + {{(ADDR_W-LEN_W){1'b0}}, last_len_r};
  assign merge      = (used_r != '0) && (tail_end == addr_r);
  assign len_sum    = {1'b0, last_len_r} + {3'b0, size};
  assign len_merge  = len_sum[LEN_W] ? LEN_MAX : len_sum[LEN_W-1:0];
  assign cap_eff    = (KW'(cap_r) > KW'(MAX_ENTRIES)) ? KW'(MAX_ENTRIES) : KW'(cap_r);
  assign full       = (KW'(used_r) >= cap_eff);
  assign left_after = left_r - n;
  assign last_region = (cnt_r == 16'd1) || (left_after == '0);
  assign stride_ext = {{(ADDR_W-40){stride_r[39]}}, stride_r};
  assign used_m1    = used_r - CW'(1);
  assign idx_x      = XW'(in_d.read_index);

  assign ram_we    = (state_r == ST_WALK) && (merge || !full);
  assign ram_waddr = merge ? used_m1[AW-1:0] : used_r[AW-1:0];
  assign ram_wdata = merge ? entry_t'{base: last_base_r, len: len_merge}
                           : entry_t'{base: addr_r, len: {2'b0, size}};
  assign ram_re    = in_acc && (in_tuser == KIND_READ);

  srib_entry_ram #(
    .DEPTH (MAX_ENTRIES),
    .AW    (AW)
  ) u_srib_entry_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (idx_x[AW-1:0]),
    .rdata (ram_rdata)
  );

  always_comb begin
    res              = '0;
    res.entries_used = ENT_W'(used_r);
    if (kind_r == KIND_APPEND) begin
      res.blocks_done  = total_r - left_r;
      res.stopped_full = stopped_r;
    end
    if ((kind_r == KIND_READ) && hit_r) begin
      res.entry_base = ram_rdata.base;
      res.entry_len  = ram_rdata.len;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      used_r      <= '0;
      cap_r       <= CAP_RESET;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr && (paddr[2] == REG_CAPACITY)) begin
        cap_r <= pwdata[CAP_W-1:0];
      end
      if (out_valid_r && out_tready && (state_r != ST_DONE)) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            kind_r    <= in_tuser;
            addr_r    <= in_d.region_address;
            left_r    <= in_d.total_blocks;
            total_r   <= in_d.total_blocks;
            cnt_r     <= in_d.region_count;
            blk_r     <= in_d.block_len;
            stride_r  <= in_d.stride;
            esize_r   <= in_d.elem_size;
            stopped_r <= 1'b0;
            hit_r     <= (idx_x < XW'(used_r));
            case (in_tuser)
              KIND_CLEAR: begin
                used_r  <= '0;
                state_r <= ST_DONE;
              end
              KIND_APPEND: begin
                if ((in_d.region_count != '0) && (in_d.total_blocks != '0)) begin
                  state_r <= ST_WALK;
                end else begin
                  state_r <= ST_DONE;
                end
              end
              default: begin
                state_r <= ST_DONE;
              end
            endcase
          end
        end
        ST_WALK: begin
          if (merge) begin
            last_len_r <= len_merge;
          end else if (full) begin
            stopped_r <= 1'b1;
            state_r   <= ST_DONE;
          end else begin
            last_base_r <= addr_r;
            last_len_r  <= {2'b0, size};
            used_r      <= used_r + CW'(1);
          end
          if (merge || !full) begin
            left_r <= left_after;
            cnt_r  <= cnt_r - 16'd1;
            addr_r <= addr_r + stride_ext;
            if (last_region) begin
              state_r <= ST_DONE;
            end
          end
        end
        ST_DONE: begin
          if (!out_valid_r || out_tready) begin
            out_data_r  <= res;
            out_valid_r <= 1'b1;
            state_r     <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

/* hdl/srib_checker.sv */
// srib_checker: port-level assertions for strided_region_iov_builder
// depends on srib_pkg for the result layout; bound to the top level below
module srib_checker
  import srib_pkg::*;
(
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_tvalid,
  input logic                   in_tready,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata
);

  out_data_t od;

  assign od = out_data_t'(out_tdata);

  // one transaction in flight: a new input waits for the result
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input accepted on the cycle after an accepted transaction");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed or dropped");

  a_stop_no_read: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && od.stopped_full |-> (od.entry_base == '0) && (od.entry_len == '0))
    else $error("full stop reported together with read data");

  a_read_no_append: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (od.entry_len != '0) |-> (od.blocks_done == '0) && !od.stopped_full)
    else $error("read data reported together with append status");

endmodule

bind strided_region_iov_builder srib_checker u_srib_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
